### src/id_bitmap_allocator_macros.svh
// Assertion shorthands for the identifier allocator.
// Both sample on clk and are disabled while arst_n is low.
`ifndef ID_BITMAP_ALLOCATOR_MACROS_SVH
`define ID_BITMAP_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ibm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ibm_pkg;

	// Map geometry
	localparam int unsigned NUM_IDS   = 4096;
	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned BIT_AW    = $clog2(WORD_BITS);
	localparam int unsigned KIDX_W    = WORD_AW + BIT_AW;

	// Field and register widths
	localparam int unsigned ID_W      = 16;
	localparam int unsigned CNT_CFG_W = 13;
	localparam int unsigned ROOM_W    = ID_W + 1;
	localparam int unsigned CNT_W     = $clog2(NUM_IDS + 1);
	localparam int unsigned CFG_DW    = ID_W;

	// Two-level lowest-free search inside one word
	localparam int unsigned GRP_W  = 8;
	localparam int unsigned GRP_N  = WORD_BITS / GRP_W;
	localparam int unsigned GRP_AW = $clog2(GRP_N);
	localparam int unsigned GBIT_AW = $clog2(GRP_W);

	// Register reset values
	localparam logic [ID_W-1:0]      BASE_ID_RST  = 16'd300;
	localparam logic [CNT_CFG_W-1:0] ID_COUNT_RST = 13'd4096;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		CFG_BASE_ID  = 1'b0,
		CFG_ID_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_REL_RD,
		S_REL_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              found;
		logic [BIT_AW-1:0] bit_idx;
	} find_res_t;

endpackage

`default_nettype wire

### src/ibm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ibm_req_if
	import ibm_pkg::*;
	();
	logic            valid;
	logic            ready;
	cmd_t            cmd;
	logic [ID_W-1:0] id_in;

	modport source (output valid, output cmd, output id_in, input ready);
	modport sink   (input valid, input cmd, input id_in, output ready);
endinterface

`default_nettype wire

### src/ibm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ibm_rsp_if
	import ibm_pkg::*;
	();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] id_out;
	status_t         status;

	modport source (output valid, output id_out, output status, input ready);
	modport sink   (input valid, input id_out, input status, output ready);
endinterface

`default_nettype wire

### src/ibm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ibm_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/ibm_find.sv
`timescale 1ns / 1ps
`default_nettype none

module ibm_find
	import ibm_pkg::*;
(
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic                 is_last,
	input  wire logic [BIT_AW-1:0]    last_b,
	output find_res_t                 res
);

	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] free;
	logic [GRP_N-1:0]     grp_any;
	logic [GRP_AW-1:0]    gsel;
	logic [GRP_W-1:0]     sub;
	logic [GBIT_AW-1:0]   bsel;

	// Only bits up to the last identifier of the range count in the last word
	assign mask = is_last ? ({WORD_BITS{1'b1}} >> (BIT_AW'(WORD_BITS - 1) - last_b))
	                      : {WORD_BITS{1'b1}};
	assign free = ~word & mask;

	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			grp_any[g] = |free[g*GRP_W +: GRP_W];
		end
	end

	// Lowest group holding a free bit, then lowest bit inside it
	always_comb begin
		gsel = '0;
		for (int g = GRP_N - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				gsel = GRP_AW'(g);
			end
		end
	end

	assign sub = free[gsel*GRP_W +: GRP_W];

	always_comb begin
		bsel = '0;
		for (int b = GRP_W - 1; b >= 0; b--) begin
			if (sub[b]) begin
				bsel = GBIT_AW'(b);
			end
		end
	end

	assign res.found   = |grp_any;
	assign res.bit_idx = {gsel, bsel};

endmodule

`default_nettype wire

### src/id_bitmap_allocator.sv
// Identifier allocator over a used-bit map. Each request beat on req either
// allocates (cmd = allocate) the lowest free identifier in base_id to
// base_id + n - 1 and returns it with status ok, or status "full" with id 0;
// or releases (cmd = release) id_in, echoing it with status ok, or status
// "out of range" with id 0 when it lies outside the range. Here n is the
// smallest of id_count, the map size (NUM_IDS = 4096) and 65536 - base_id.
// Exactly one response beat leaves on rsp for every request beat. The map is
// a 64 x 64-bit RAM plus one valid flop per word that reset clears, so the map
// reads as all free right after reset with no clearing pass. Changing base_id
// or id_count does not clear the map: bit k then stands for the new base + k.
// Write the registers only while the block is idle. Timing: one request at a
// time. An allocate reads one map word per cycle from the RAM read port and
// scans at most ceil(n/64) words, 64 for a full 4096-id range; a failed range
// check or an empty range goes straight to the response, and a release reads,
// modifies and writes back one map word. The response register frees the
// request side: a new request is taken while the last response still waits.
`timescale 1ns / 1ps
`default_nettype none
`include "id_bitmap_allocator_macros.svh"

module id_bitmap_allocator
	import ibm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire cfg_idx_t          cfg_idx,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	ibm_req_if.sink                req,
	ibm_rsp_if.source              rsp
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [ID_W-1:0]      base_q;
	logic [CNT_CFG_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_ID_RST;
			cnt_q  <= ID_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_BASE_ID:  base_q <= cfg_wdata[ID_W-1:0];
				CFG_ID_COUNT: cnt_q  <= cfg_wdata[CNT_CFG_W-1:0];
				default:      base_q <= base_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Effective range size: clip the count to the map and to the id space
	// ------------------------------------------------------------------
	logic [ROOM_W-1:0] room;
	logic [ROOM_W-1:0] cnt_clip;
	logic [ROOM_W-1:0] n_full;
	logic [CNT_W-1:0]  eff_n;
	logic [CNT_W-1:0]  nm1;
	logic [ROOM_W-1:0] rel_k_full;
	logic              rel_in_range;

	assign room     = {1'b1, {ID_W{1'b0}}} - {1'b0, base_q};
	assign cnt_clip = (ROOM_W'(cnt_q) > ROOM_W'(NUM_IDS)) ? ROOM_W'(NUM_IDS)
	                                                      : ROOM_W'(cnt_q);
	assign n_full   = (room < cnt_clip) ? room : cnt_clip;
	assign eff_n    = n_full[CNT_W-1:0];
	assign nm1      = eff_n - CNT_W'(1);

	// Release offset and range check on the incoming beat
	assign rel_k_full   = {1'b0, req.id_in} - {1'b0, base_q};
	assign rel_in_range = (req.id_in >= base_q) && (rel_k_full < n_full);

	// ------------------------------------------------------------------
	// Map storage: one RAM word per 64 identifiers, valid flop per word
	// ------------------------------------------------------------------
	logic                 ram_we;
	logic [WORD_AW-1:0]   ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WORD_AW-1:0]   ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [MAP_WORDS-1:0] word_vld_q;

	ibm_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
		end else if (ram_we) begin
			word_vld_q[ram_waddr] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_t               state_q, state_d;
	logic [ID_W-1:0]      id_q;
	logic [KIDX_W-1:0]    rel_k_q;
	logic [WORD_AW-1:0]   last_w_q;
	logic [BIT_AW-1:0]    last_b_q;
	logic [WORD_AW-1:0]   rd_w_q;
	logic                 rd_more_q;
	logic [ID_W-1:0]      res_id_q;
	status_t              res_st_q;

	// Read-data stage: word index and entry-valid of the read in flight
	logic                 ev_vld_s1;
	logic [WORD_AW-1:0]   ev_w_s1;
	logic                 ev_dvld_s1;
	logic [WORD_BITS-1:0] rd_word;

	// Response register
	logic                 rsp_vld_q;
	logic [ID_W-1:0]      rsp_id_q;
	status_t              rsp_st_q;

	logic                 req_ready;
	logic                 req_acc;
	logic                 done_load;
	logic                 res_ld;
	logic [ID_W-1:0]      res_id_d;
	status_t              res_st_d;
	find_res_t            fres;
	logic                 is_last;
	logic [WORD_BITS-1:0] bit_one;

	assign req_acc = req.valid && req_ready;

	// Never-written words read as all free
	assign rd_word = ev_dvld_s1 ? ram_rdata : '0;
	assign is_last = (ev_w_s1 == last_w_q);

	ibm_find u_find (
		.word    (rd_word),
		.is_last (is_last),
		.last_b  (last_b_q),
		.res     (fres)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (req.cmd == CMD_ALLOC) begin
						state_d = (eff_n == '0) ? S_DONE : S_SCAN;
					end else begin
						state_d = rel_in_range ? S_REL_RD : S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (ev_vld_s1 && (fres.found || is_last)) begin
					state_d = S_DONE;
				end
			end
			S_REL_RD: state_d = S_REL_WR;
			S_REL_WR: state_d = S_DONE;
			S_DONE: begin
				if (done_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: RAM port controls and result capture
	always_comb begin
		req_ready = 1'b0;
		done_load = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rd_w_q;
		ram_we    = 1'b0;
		ram_waddr = ev_w_s1;
		ram_wdata = rd_word;
		res_ld    = 1'b0;
		res_id_d  = '0;
		res_st_d  = STAT_OK;
		bit_one   = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_acc) begin
					if (req.cmd == CMD_ALLOC) begin
						if (eff_n == '0) begin
							res_ld   = 1'b1;
							res_st_d = STAT_FULL;
						end
					end else if (!rel_in_range) begin
						res_ld   = 1'b1;
						res_st_d = STAT_RANGE;
					end
				end
			end
			S_SCAN: begin
				ram_re  = rd_more_q;
				bit_one = WORD_BITS'(1) << fres.bit_idx;
				if (ev_vld_s1) begin
					if (fres.found) begin
						// Mark the lowest free bit and hand out base + k
						ram_we    = 1'b1;
						ram_wdata = rd_word | bit_one;
						res_ld    = 1'b1;
						res_id_d  = base_q + ID_W'({ev_w_s1, fres.bit_idx});
						res_st_d  = STAT_OK;
					end else if (is_last) begin
						res_ld   = 1'b1;
						res_st_d = STAT_FULL;
					end
				end
			end
			S_REL_RD: begin
				ram_re    = 1'b1;
				ram_raddr = rel_k_q[KIDX_W-1:BIT_AW];
			end
			S_REL_WR: begin
				bit_one   = WORD_BITS'(1) << rel_k_q[BIT_AW-1:0];
				ram_we    = 1'b1;
				ram_waddr = rel_k_q[KIDX_W-1:BIT_AW];
				ram_wdata = rd_word & ~bit_one;
				res_ld    = 1'b1;
				res_id_d  = id_q;
				res_st_d  = STAT_OK;
			end
			S_DONE: begin
				done_load = !rsp_vld_q || rsp.ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	assign req.ready = req_ready;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_more_q <= 1'b0;
			ev_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			ev_vld_s1 <= ram_re && (state_q == S_SCAN);
			// Start the scan at word 0; stop issuing after the last word
			if (req_acc && (req.cmd == CMD_ALLOC) && (eff_n != '0)) begin
				rd_more_q <= 1'b1;
			end else if (state_d != S_SCAN) begin
				rd_more_q <= 1'b0;
			end else if (ram_re && (rd_w_q == last_w_q)) begin
				rd_more_q <= 1'b0;
			end
		end
	end

	// Payload registers of the sequencer
	always_ff @(posedge clk) begin
		ev_w_s1    <= ram_raddr;
		ev_dvld_s1 <= word_vld_q[ram_raddr];
		if (req_acc) begin
			id_q     <= req.id_in;
			rel_k_q  <= rel_k_full[KIDX_W-1:0];
			last_w_q <= nm1[KIDX_W-1:BIT_AW];
			last_b_q <= nm1[BIT_AW-1:0];
			rd_w_q   <= '0;
		end else if (ram_re && (state_q == S_SCAN) && (rd_w_q != last_w_q)) begin
			rd_w_q <= rd_w_q + WORD_AW'(1);
		end
		if (res_ld) begin
			res_id_q <= res_id_d;
			res_st_q <= res_st_d;
		end
	end

	// Response register: load when empty or as the old beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (done_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_load) begin
			rsp_id_q <= res_id_q;
			rsp_st_q <= res_st_q;
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.id_out = rsp_id_q;
	assign rsp.status = rsp_st_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// One request in flight: the beat after an accept finds the port closed
	`IBM_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready,
		"request accepted while another is in progress")
	// A write-back never targets the word being read in the same cycle
	`IBM_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
		"map write and read collide on one word")
	// A found bit lies inside the effective range
	`IBM_ASSERT_NOW(a_alloc_in_range, (state_q == S_SCAN) && ev_vld_s1 && fres.found,
		{ev_w_s1, fres.bit_idx} <= {last_w_q, last_b_q},
		"allocated bit beyond the end of the range")

endmodule

`default_nettype wire

### sim/tb_id_bitmap_allocator.sv
`timescale 1ns / 1ps

module tb_id_bitmap_allocator;
	import ibm_pkg::*;

	// Run limit in clock cycles: several times what the slowest correct run of
	// about 1850 beats needs with the longest scans, sender gaps and receiver
	// stalls.
	localparam int unsigned RUN_LIMIT  = 1_000_000;
	// An allocate over a full 4096-id range scans up to 64 map words.
	localparam int unsigned SCAN_CYCLES = 70;
	localparam int unsigned IDLE_GAP    = 4;

	typedef struct packed {
		logic [ID_W-1:0] id_out;
		status_t         status;
	} reply_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	cfg_idx_t            cfg_idx   = CFG_BASE_ID;
	logic [CFG_DW-1:0]   cfg_wdata = '0;

	ibm_req_if req_ch ();
	ibm_rsp_if rsp_ch ();

	id_bitmap_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	// Our own copy of the used-bit map and the two registers. Bit k belongs to
	// identifier cur_base + k, whatever the registers held when it was set.
	bit          id_taken [NUM_IDS];
	int unsigned cur_base;
	int unsigned cur_count;

	reply_t      expected_replies [$];

	// Idle behavior of the two sides, redrawn per stretch of beats
	bit          src_gaps_on   = 1'b1;
	bit          snk_stalls_on = 1'b1;
	int unsigned rsp_hold_cycles = 0;

	int unsigned error_cnt   = 0;
	int unsigned cycle_cnt   = 0;
	int unsigned n_granted   = 0;
	int unsigned n_full      = 0;
	int unsigned n_released  = 0;
	int unsigned n_rejected  = 0;
	int unsigned n_settings  = 1;

	// Size of the live range: the count, clipped to the map and to the top
	// of the 16-bit identifier space.
	function automatic int unsigned live_span();
		int unsigned n;
		n = cur_count;
		if (n > NUM_IDS)
			n = NUM_IDS;
		if (n > 65536 - cur_base)
			n = 65536 - cur_base;
		return n;
	endfunction

	// Work out the reply to one request and apply it to the map copy.
	function automatic reply_t compute_reply(input cmd_t c, input logic [ID_W-1:0] id);
		reply_t          r;
		int unsigned     n;
		int unsigned     k;
		int unsigned     idv;
		logic [ID_W-1:0] grant;
		n = live_span();
		r.id_out = '0;
		r.status = STAT_OK;
		if (c == CMD_ALLOC) begin
			// Lowest free bit wins; none free means the range is full
			r.status = STAT_FULL;
			for (k = 0; k < n; k++) begin
				if (!id_taken[k]) begin
					id_taken[k] = 1'b1;
					grant = ID_W'(cur_base + k);
					r.id_out = grant;
					r.status = STAT_OK;
					break;
				end
			end
		end else begin
			// Below the base or past the end of the range: reject, map untouched.
			// Releasing an id that is already free is fine.
			idv = 32'(id);
			if (idv < cur_base || idv - cur_base >= n) begin
				r.status = STAT_RANGE;
			end else begin
				id_taken[idv - cur_base] = 1'b0;
				r.id_out = id;
			end
		end
		return r;
	endfunction

	// Pick an identifier to release: mostly one that is in use, some anywhere
	// in the range, some at the range edges, some anywhere at all.
	function automatic logic [ID_W-1:0] pick_release_id();
		int unsigned     n;
		int unsigned     k;
		int unsigned     tries;
		int unsigned     sel;
		logic [ID_W-1:0] pick;
		n = live_span();
		sel = $urandom_range(0, 99);
		pick = ID_W'($urandom);
		if (n == 0 || sel >= 90)
			return pick;
		if (sel >= 80) begin
			case ($urandom_range(0, 3))
				0: pick = ID_W'(cur_base - 1);
				1: pick = ID_W'(cur_base + n);
				2: pick = ID_W'(cur_base);
				default: pick = ID_W'(cur_base + n - 1);
			endcase
			return pick;
		end
		pick = ID_W'(cur_base + $urandom_range(0, n - 1));
		if (sel >= 70)
			return pick;
		for (tries = 0; tries < 16; tries++) begin
			k = $urandom_range(0, n - 1);
			if (id_taken[k]) begin
				pick = ID_W'(cur_base + k);
				return pick;
			end
		end
		return pick;
	endfunction

	// Offer one request beat after a random gap; predict its reply on accept.
	// Valid stays high on return so that a zero gap gives back-to-back beats.
	task automatic send_req(input cmd_t c, input logic [ID_W-1:0] id);
		int unsigned gap;
		reply_t      r;
		gap = src_gaps_on ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= c;
		req_ch.id_in <= id;
		do @(posedge clk); while (!req_ch.ready);
		r = compute_reply(c, id);
		expected_replies.push_back(r);
	endtask

	// Drop valid and hold until every predicted reply has come back. One
	// request yields one reply, so the block is idle after a short gap.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx == CFG_BASE_ID)
			cur_base = 32'(value);
		else
			cur_count = 32'(value[CNT_CFG_W-1:0]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram the range while idle. The map is kept on purpose.
	task automatic set_range(input int unsigned base, input int unsigned count);
		wait_drained();
		write_reg(CFG_BASE_ID, CFG_DW'(base));
		write_reg(CFG_ID_COUNT, CFG_DW'(count));
		n_settings++;
	endtask

	// Random traffic; redraw the idle behavior of both sides every 50 beats
	// so that stretches without gaps occur too.
	task automatic run_mix(input int unsigned beats, input int unsigned alloc_pct);
		int unsigned     i;
		logic [ID_W-1:0] noise_id;
		for (i = 0; i < beats; i++) begin
			if (i % 50 == 0) begin
				src_gaps_on   = ($urandom_range(0, 3) != 0);
				snk_stalls_on = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 99) < alloc_pct) begin
				noise_id = ID_W'($urandom);
				send_req(CMD_ALLOC, noise_id);
			end else begin
				send_req(CMD_RELEASE, pick_release_id());
			end
		end
	endtask

	// Directed checks on the reset range (base 300, 4096 ids) and on the
	// special ranges: empty, one id at the very top, one id at zero, and a
	// range that ends one id below the top of the identifier space.
	task automatic test_directed();
		send_req(CMD_ALLOC, 16'h0000);
		send_req(CMD_ALLOC, 16'h0000);
		send_req(CMD_RELEASE, 16'd300);
		send_req(CMD_RELEASE, 16'd300);       // already free
		send_req(CMD_ALLOC, 16'hFFFF);        // id_in is ignored here
		send_req(CMD_RELEASE, 16'd299);       // just below the base
		send_req(CMD_RELEASE, 16'd4396);      // just past the end
		send_req(CMD_RELEASE, 16'd4395);      // last id of the range
		send_req(CMD_RELEASE, 16'hFFFF);
		send_req(CMD_RELEASE, 16'h0000);
		send_req(CMD_ALLOC, 16'h5A5A);

		// Empty range: allocate reports full, every release is out of range
		set_range(300, 0);
		send_req(CMD_ALLOC, 16'h0000);
		send_req(CMD_RELEASE, 16'd300);

		// Count above the map size, base at the top: one id left
		set_range(65535, 8191);
		send_req(CMD_ALLOC, 16'h0000);
		send_req(CMD_RELEASE, 16'hFFFF);
		send_req(CMD_ALLOC, 16'h0000);
		send_req(CMD_RELEASE, 16'hFFFE);

		// Single id at zero
		set_range(0, 1);
		send_req(CMD_ALLOC, 16'h0000);
		send_req(CMD_RELEASE, 16'd1);
		send_req(CMD_RELEASE, 16'd0);

		// Full 4096-id range that ends one id below the top of the identifier space
		set_range(61439, 4096);
		send_req(CMD_ALLOC, 16'h0000);
		send_req(CMD_ALLOC, 16'h0000);
		send_req(CMD_RELEASE, 16'hFFFE);
		send_req(CMD_RELEASE, 16'hFFFF);
	endtask

	// Small ranges fill up fast, so full replies and reuse of released ids
	// come often.
	task automatic test_small_ranges();
		int unsigned bases  [6] = '{0, 1000, 5000, 65472, 127, 40000};
		int unsigned counts [6] = '{64, 130, 1, 64, 65, 200};
		int unsigned i;
		for (i = 0; i < 6; i++) begin
			set_range(bases[i], counts[i]);
			run_mix(100, 60);
		end
	endtask

	// Full range with mostly allocates so the scan walks past many full
	// words, then a balanced mix over the filled map.
	task automatic test_deep_scan();
		set_range(300, 4096);
		run_mix(500, 90);
		run_mix(200, 50);
	endtask

	// Hold the receiver off for a long stretch while the sender keeps
	// offering, so the block fills and stalls its request side. Then pause
	// the sender until every reply is back and go on.
	task automatic test_backpressure();
		set_range(2000, 96);
		src_gaps_on   = 1'b0;
		rsp_hold_cycles = 300;
		run_mix(40, 60);
		wait_drained();
		run_mix(40, 60);
	endtask

	task automatic test_random_settings();
		int unsigned i;
		int unsigned base;
		int unsigned count;
		for (i = 0; i < 5; i++) begin
			case ($urandom_range(0, 3))
				0: base = $urandom_range(0, 1023);
				1: base = $urandom_range(0, 61439);
				default: base = $urandom_range(61440, 65535);
			endcase
			count = ($urandom_range(0, 4) == 0) ? 4096 : $urandom_range(1, 260);
			set_range(base, count);
			run_mix(80, 55);
		end
	endtask

	// Receiver ready: a random stall per beat, or one long hold-off when a
	// test asks for it. Ready is only lowered when a stall is due, so a
	// held-high ready never gets two updates in one step.
	initial begin : rsp_ready_driver
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_hold_cycles != 0) begin
				stall = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else begin
				stall = snk_stalls_on ? $urandom_range(0, 4) : 0;
			end
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	// Compare every accepted reply beat with the oldest prediction.
	always @(posedge clk) begin : reply_checker
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$error("reply with nothing outstanding: id_out %0d status %0d",
					rsp_ch.id_out, rsp_ch.status);
				error_cnt++;
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.id_out !== want.id_out) begin
					$error("id_out: expected %0d, got %0d", want.id_out, rsp_ch.id_out);
					error_cnt++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					error_cnt++;
				end
				case (want.status)
					STAT_FULL:  n_full++;
					STAT_RANGE: n_rejected++;
					default: begin
						if (want.id_out == rsp_ch.id_out && rsp_ch.status == STAT_OK)
							;
					end
				endcase
			end
		end
	end

	// Count the accepted requests by kind, as they are predicted
	always @(posedge clk) begin : grant_tally
		if (arst_n && req_ch.valid && req_ch.ready) begin
			if (req_ch.cmd == CMD_ALLOC)
				n_granted++;
			else
				n_released++;
		end
	end

	// Timeout: end the run if it hangs
	initial begin : watchdog
		while (cycle_cnt < RUN_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_id_bitmap_allocator: FAIL");
		$finish;
	end

	initial begin : main_seq
		int unsigned i;
		req_ch.valid <= 1'b0;
		req_ch.cmd   <= CMD_ALLOC;
		req_ch.id_in <= '0;

		// Mirror the register reset values and the cleared map
		for (i = 0; i < NUM_IDS; i++)
			id_taken[i] = 1'b0;
		cur_base  = 32'(BASE_ID_RST);
		cur_count = 32'(ID_COUNT_RST);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_small_ranges();
		test_deep_scan();
		test_backpressure();
		test_random_settings();

		// Drain, then give a stray extra reply time to show up
		wait_drained();
		repeat (SCAN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d allocates (%0d found the range full),",
			n_granted + n_released, n_granted, n_full);
		$display("  %0d releases (%0d out of range), over %0d register settings",
			n_released, n_rejected, n_settings);
		if (error_cnt == 0)
			$display("tb_id_bitmap_allocator: PASS");
		else
			$display("tb_id_bitmap_allocator: FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/ibm_pkg.sv
src/ibm_req_if.sv
src/ibm_rsp_if.sv
src/ibm_ram.sv
src/ibm_find.sv
src/id_bitmap_allocator.sv
sim/tb_id_bitmap_allocator.sv
